@@ hw/rtl/double_couple_radiation_pattern_core_macros.svh @@
// Assertion macros used by the radiation pattern top level.
`ifndef DOUBLE_COUPLE_RADIATION_PATTERN_CORE_MACROS_SVH
`define DOUBLE_COUPLE_RADIATION_PATTERN_CORE_MACROS_SVH

// Condition holds in the same cycle as the trigger.
`define DCRP_ASSERT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Condition holds in the cycle after the trigger.
`define DCRP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/dcrp_pkg.sv @@
// Shared types, constants and fixed-point helpers of the radiation pattern core.
`default_nettype none
package dcrp_pkg;

  localparam int Q_W = 32;
  typedef logic signed [Q_W-1:0] q_t;
  typedef logic signed [Q_W:0]   qw_t;
  typedef logic signed [34:0]    sum_t;

  typedef enum logic [1:0] {
    OP_P   = 2'd0,
    OP_SV  = 2'd1,
    OP_SH  = 2'd2,
    OP_BAD = 2'd3
  } op_t;

  typedef struct packed {
    logic valid;
    op_t  op;
  } ctl_t;

  typedef enum logic [1:0] {
    REG_STRIKE = 2'd0,
    REG_DIP    = 2'd1,
    REG_RAKE   = 2'd2,
    REG_NONE   = 2'd3
  } reg_idx_t;

  // Angle lanes, one CORDIC each.
  localparam int N_LANES = 7;
  localparam int LANE_R  = 0;
  localparam int LANE_D  = 1;
  localparam int LANE_2D = 2;
  localparam int LANE_T  = 3;
  localparam int LANE_2T = 4;
  localparam int LANE_A  = 5;
  localparam int LANE_2A = 6;

  localparam int CORDIC_ITERS = 30;
  localparam int CORDIC_LAT   = CORDIC_ITERS + 2;
  localparam q_t X_INIT = 32'sd652032874;

  localparam logic [31:0] ATAN_TAB [CORDIC_ITERS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
  };

  // Binary angle: bang = m*119304 + floor((1456*m + 1125) / 2250).
  localparam logic [16:0] BANG_INT  = 17'd119304;
  localparam logic [10:0] BANG_MUL  = 11'd1456;
  localparam logic [10:0] BANG_ADD  = 11'd1125;
  localparam logic [25:0] BANG_RECIP = 26'd61083980;  // ceil(2^37 / 2250)
  localparam int          BANG_SHIFT = 37;

  localparam qw_t  QW_ONE  = 33'sd1073741824;
  localparam sum_t SUM_NEG_ONE = -35'sd1073741824;

  function automatic qw_t qx(input q_t v);
    return qw_t'(v);
  endfunction

  // Q1.30 product rounded back to Q1.30 (half up, floor shift).
  function automatic qw_t qmul(input qw_t a, input qw_t b);
    logic signed [65:0] p;
    p = a * b;
    p = p + 66'sd536870912;
    return qw_t'(p >>> 30);
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/dcrp_angle.sv @@
// Angle formation, modulo reduction and conversion to 32-bit binary angles.
`default_nettype none
module dcrp_angle
  import dcrp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic [15:0]        strike,
  input  logic [13:0]        dip,
  input  logic signed [15:0] rake,
  input  logic [15:0]        azimuth,
  input  logic [14:0]        takeoff,
  input  ctl_t               ctl_in,
  output logic [31:0]        bang [N_LANES],
  output ctl_t               ctl_out
);

  logic [15:0] m_now [N_LANES];
  logic [15:0] m1 [N_LANES];
  logic [15:0] m2 [N_LANES];
  logic [15:0] m3 [N_LANES];
  logic [25:0] xv [N_LANES];
  logic [14:0] qv [N_LANES];
  logic [51:0] prod [N_LANES];
  ctl_t        ctl1, ctl2, ctl3;

  logic signed [16:0] rk;
  logic signed [17:0] da, t1, t2;
  logic [16:0]        a2;
  logic [15:0]        tk2;

  always_comb begin
    rk  = 17'(rake);
    da  = signed'({2'b00, azimuth}) - signed'({2'b00, strike});
    t1  = da[17] ? da + 18'sd36000 : da;
    // A difference of two angles below 655.36 degrees needs at most two folds.
    if (t1[17]) begin
      t2 = t1 + 18'sd36000;
    end else if (t1 >= 18'sd36000) begin
      t2 = t1 - 18'sd36000;
    end else begin
      t2 = t1;
    end
    a2  = {t2[15:0], 1'b0};
    tk2 = {takeoff, 1'b0};
    m_now[LANE_R]  = rk[16] ? 16'(rk + 17'sd36000) : 16'(rk);
    m_now[LANE_D]  = {2'b00, dip};
    m_now[LANE_2D] = {1'b0, dip, 1'b0};
    m_now[LANE_T]  = {1'b0, takeoff};
    m_now[LANE_2T] = (tk2 >= 16'd36000) ? tk2 - 16'd36000 : tk2;
    m_now[LANE_A]  = t2[15:0];
    m_now[LANE_2A] = (a2 >= 17'd36000) ? 16'(a2 - 17'd36000) : a2[15:0];
  end

  always_comb begin
    for (int l = 0; l < N_LANES; l++) begin
      prod[l] = 52'(xv[l]) * 52'(BANG_RECIP);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < N_LANES; l++) begin
        m1[l]   <= m_now[l];
        xv[l]   <= 26'(m1[l]) * 26'(BANG_MUL) + 26'(BANG_ADD);
        m2[l]   <= m1[l];
        qv[l]   <= prod[l][51:BANG_SHIFT];
        m3[l]   <= m2[l];
        bang[l] <= 32'(m3[l]) * 32'(BANG_INT) + 32'(qv[l]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1.valid    <= 1'b0;
      ctl2.valid    <= 1'b0;
      ctl3.valid    <= 1'b0;
      ctl_out.valid <= 1'b0;
    end else if (en) begin
      ctl1    <= ctl_in;
      ctl2    <= ctl1;
      ctl3    <= ctl2;
      ctl_out <= ctl3;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/dcrp_cordic.sv @@
// Pipelined rotation CORDIC: binary angle in, Q1.30 sine and cosine out.
`default_nettype none
module dcrp_cordic
  import dcrp_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] bang,
  output q_t          sn,
  output q_t          cs
);

  q_t                 x [CORDIC_ITERS+1];
  q_t                 y [CORDIC_ITERS+1];
  logic signed [32:0] r [CORDIC_ITERS+1];
  logic               flip [CORDIC_ITERS+1];

  logic        fold;
  logic [31:0] zf;

  always_comb begin
    // Angles in the left half plane turn by half a circle and negate at the end.
    fold = (bang - 32'h4000_0000) < 32'h8000_0000;
    zf   = fold ? bang + 32'h8000_0000 : bang;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x[0]    <= X_INIT;
      y[0]    <= '0;
      r[0]    <= 33'(signed'(zf));
      flip[0] <= fold;
      for (int i = 0; i < CORDIC_ITERS; i++) begin
        if (!r[i][32]) begin
          x[i+1] <= x[i] - (y[i] >>> i);
          y[i+1] <= y[i] + (x[i] >>> i);
          r[i+1] <= r[i] - signed'({1'b0, ATAN_TAB[i]});
        end else begin
          x[i+1] <= x[i] + (y[i] >>> i);
          y[i+1] <= y[i] - (x[i] >>> i);
          r[i+1] <= r[i] + signed'({1'b0, ATAN_TAB[i]});
        end
        flip[i+1] <= flip[i];
      end
      sn <= flip[CORDIC_ITERS] ? -y[CORDIC_ITERS] : y[CORDIC_ITERS];
      cs <= flip[CORDIC_ITERS] ? -x[CORDIC_ITERS] : x[CORDIC_ITERS];
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/dcrp_combine.sv @@
// Product tree of the P, SV and SH formulas and selection of the component.
`default_nettype none
module dcrp_combine
  import dcrp_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  ctl_t ctl_in,
  input  q_t   sn [N_LANES],
  input  q_t   cs [N_LANES],
  output ctl_t ctl_out,
  output sum_t sum
);

  ctl_t ctl1, ctl2, ctl3;

  // First level.
  q_t st2_1, sa2_1, ct2_1, crsd_1, crcd_1, src2d_1, srs2d_1, s2ts2a_1, sts2a_1;
  q_t hcr_1, hsr_1;
  q_t sd_1, s2d_1, s2t_1, c2t_1, st_1, ct_1, sa_1, ca_1, s2a_1, c2a_1;
  // Second level.
  q_t  a1_2, b1_2, st2sa2_2, d1_2, e1_2, f1_2, g1_2, h1_2, i1_2, j1_2, k1_2;
  qw_t h2_2;
  q_t  ct2_2, srs2d_2, s2ts2a_2, sts2a_2, sa_2, ca_2, s2a_2, c2a_2;
  // Third level: the twelve terms.
  q_t p0, p1, p2, p3, v0, v1, v2, v3, h0, h1, h2, h3;

  qw_t diff;

  always_comb begin
    diff = qx(ct2_2) - qx(st2sa2_2);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st2_1    <= q_t'(qmul(qx(sn[LANE_T]), qx(sn[LANE_T])));
      sa2_1    <= q_t'(qmul(qx(sn[LANE_A]), qx(sn[LANE_A])));
      ct2_1    <= q_t'(qmul(qx(cs[LANE_T]), qx(cs[LANE_T])));
      crsd_1   <= q_t'(qmul(qx(cs[LANE_R]), qx(sn[LANE_D])));
      crcd_1   <= q_t'(qmul(qx(cs[LANE_R]), qx(cs[LANE_D])));
      src2d_1  <= q_t'(qmul(qx(sn[LANE_R]), qx(cs[LANE_2D])));
      srs2d_1  <= q_t'(qmul(qx(sn[LANE_R]), qx(sn[LANE_2D])));
      s2ts2a_1 <= q_t'(qmul(qx(sn[LANE_2T]), qx(sn[LANE_2A])));
      sts2a_1  <= q_t'(qmul(qx(sn[LANE_T]), qx(sn[LANE_2A])));
      // A product with one half reduces to a rounded halving.
      hcr_1    <= q_t'((qx(cs[LANE_R]) + 33'sd1) >>> 1);
      hsr_1    <= q_t'((qx(sn[LANE_R]) + 33'sd1) >>> 1);
      sd_1     <= sn[LANE_D];
      s2d_1    <= sn[LANE_2D];
      s2t_1    <= sn[LANE_2T];
      c2t_1    <= cs[LANE_2T];
      st_1     <= sn[LANE_T];
      ct_1     <= cs[LANE_T];
      sa_1     <= sn[LANE_A];
      ca_1     <= cs[LANE_A];
      s2a_1    <= sn[LANE_2A];
      c2a_1    <= cs[LANE_2A];

      a1_2     <= q_t'(qmul(qx(crsd_1), qx(st2_1)));
      b1_2     <= q_t'(qmul(qx(crcd_1), qx(s2t_1)));
      st2sa2_2 <= q_t'(qmul(qx(st2_1), qx(sa2_1)));
      d1_2     <= q_t'(qmul(qx(src2d_1), qx(s2t_1)));
      e1_2     <= q_t'(qmul(qx(src2d_1), qx(c2t_1)));
      f1_2     <= q_t'(qmul(qx(crcd_1), qx(c2t_1)));
      g1_2     <= q_t'(qmul(qx(hcr_1), qx(sd_1)));
      h1_2     <= q_t'(qmul(qx(hsr_1), qx(s2d_1)));
      h2_2     <= qmul(qx(s2t_1), QW_ONE + qx(sa2_1));
      i1_2     <= q_t'(qmul(qx(crcd_1), qx(ct_1)));
      j1_2     <= q_t'(qmul(qx(crsd_1), qx(st_1)));
      k1_2     <= q_t'(qmul(qx(src2d_1), qx(ct_1)));
      ct2_2    <= ct2_1;
      srs2d_2  <= srs2d_1;
      s2ts2a_2 <= s2ts2a_1;
      sts2a_2  <= sts2a_1;
      sa_2     <= sa_1;
      ca_2     <= ca_1;
      s2a_2    <= s2a_1;
      c2a_2    <= c2a_1;

      p0 <= q_t'(qmul(qx(a1_2), qx(s2a_2)));
      p1 <= q_t'(qmul(qx(b1_2), qx(ca_2)));
      p2 <= q_t'(qmul(qx(srs2d_2), diff));
      p3 <= q_t'(qmul(qx(d1_2), qx(sa_2)));
      v0 <= q_t'(qmul(qx(e1_2), qx(sa_2)));
      v1 <= q_t'(qmul(qx(f1_2), qx(ca_2)));
      v2 <= q_t'(qmul(qx(g1_2), qx(s2ts2a_2)));
      v3 <= q_t'(qmul(qx(h1_2), h2_2));
      h0 <= q_t'(qmul(qx(i1_2), qx(sa_2)));
      h1 <= q_t'(qmul(qx(j1_2), qx(c2a_2)));
      h2 <= q_t'(qmul(qx(k1_2), qx(ca_2)));
      h3 <= q_t'(qmul(qx(h1_2), qx(sts2a_2)));

      unique case (ctl3.op)
        OP_P:    sum <= sum_t'(p0) - sum_t'(p1) + sum_t'(p2) + sum_t'(p3);
        OP_SV:   sum <= sum_t'(v0) - sum_t'(v1) + sum_t'(v2) - sum_t'(v3);
        OP_SH:   sum <= sum_t'(h0) + sum_t'(h1) + sum_t'(h2) - sum_t'(h3);
        default: sum <= SUM_NEG_ONE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1.valid    <= 1'b0;
      ctl2.valid    <= 1'b0;
      ctl3.valid    <= 1'b0;
      ctl_out.valid <= 1'b0;
    end else if (en) begin
      ctl1    <= ctl_in;
      ctl2    <= ctl1;
      ctl3    <= ctl2;
      ctl_out <= ctl3;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/double_couple_radiation_pattern_core.sv @@
// Top level of the double-couple radiation pattern core.
//
//   channel  direction  payload
//   s_*      in         ray azimuth, take-off angle, component selector
//   m_*      out        amplitude, bad component flag
//   cfg_*    in         fault strike, dip and rake registers
//
// One item per cycle while s_tready is high, through 42 register stages: four
// angle conversion stages, 32 CORDIC stages, three product stages, a sum stage,
// one rounding stage and the output register. Synchronous reset (rst) clears
// the valid flags and fault registers and so empties the pipeline.
// A held result parks in a one-item skid register; only while that is full
// does s_tready drop and the whole pipeline hold still.
`default_nettype none
`include "double_couple_radiation_pattern_core_macros.svh"
module double_couple_radiation_pattern_core
  import dcrp_pkg::*;
#(
  parameter int AMP_FRAC_BITS = 14
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // ray_azimuth[15:0], takeoff_angle[30:16]
  input  logic [1:0]  s_tuser,   // op[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // amplitude[15:0]
  output logic [0:0]  m_tuser,   // bad_component[0]
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  localparam int K = 30 - AMP_FRAC_BITS;
  localparam logic signed [35:0] RND = (K > 0) ? (36'sd1 <<< ((K > 0) ? K - 1 : 0)) : 36'sd0;
  localparam logic signed [15:0] ERR_AMP =
    (AMP_FRAC_BITS >= 15) ? 16'sh8000 : 16'(-(32'sd1 <<< AMP_FRAC_BITS));

  logic [15:0]        strike;
  logic [13:0]        dip;
  logic signed [15:0] rake;

  logic        en;
  ctl_t        ctl_in, ctl_ang, ctl_cmb, r_ctl;
  ctl_t        ctl_d [CORDIC_LAT];
  logic [31:0] bang [N_LANES];
  q_t          sn [N_LANES];
  q_t          cs [N_LANES];
  sum_t        c_sum;

  logic signed [35:0] rsum;
  logic signed [15:0] sat_amp;
  logic signed [15:0] r_amp;

  logic               out_v, skid_v;
  logic signed [15:0] out_amp, skid_amp;
  logic               out_bad, skid_bad;

  always_ff @(posedge clk) begin
    if (rst) begin
      strike <= '0;
      dip    <= '0;
      rake   <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_STRIKE: strike <= cfg_wdata;
        REG_DIP:    dip    <= cfg_wdata[13:0];
        REG_RAKE:   rake   <= signed'(cfg_wdata);
        default:    ;
      endcase
    end
  end

  assign en       = !skid_v;
  assign s_tready = en;

  always_comb begin
    ctl_in.valid = s_tvalid;
    ctl_in.op    = op_t'(s_tuser);
  end

  dcrp_angle u_angle (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .strike  (strike),
    .dip     (dip),
    .rake    (rake),
    .azimuth (s_tdata[15:0]),
    .takeoff (s_tdata[30:16]),
    .ctl_in  (ctl_in),
    .bang    (bang),
    .ctl_out (ctl_ang)
  );

  for (genvar l = 0; l < N_LANES; l++) begin : g_lane
    dcrp_cordic u_cordic (
      .clk  (clk),
      .en   (en),
      .bang (bang[l]),
      .sn   (sn[l]),
      .cs   (cs[l])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CORDIC_LAT; i++) begin
        ctl_d[i].valid <= 1'b0;
      end
    end else if (en) begin
      ctl_d[0] <= ctl_ang;
      for (int i = 1; i < CORDIC_LAT; i++) begin
        ctl_d[i] <= ctl_d[i-1];
      end
    end
  end

  dcrp_combine u_combine (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .ctl_in  (ctl_d[CORDIC_LAT-1]),
    .sn      (sn),
    .cs      (cs),
    .ctl_out (ctl_cmb),
    .sum     (c_sum)
  );

  always_comb begin
    rsum = (36'(c_sum) + RND) >>> K;
    if (rsum > 36'sd32767) begin
      sat_amp = 16'sh7FFF;
    end else if (rsum < -36'sd32768) begin
      sat_amp = 16'sh8000;
    end else begin
      sat_amp = rsum[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r_ctl.valid <= 1'b0;
    end else if (en) begin
      r_ctl <= ctl_cmb;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_amp <= sat_amp;
    end
  end

  // The skid register only fills while the output register is held.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      skid_v <= 1'b0;
    end else if (!out_v || m_tready) begin
      if (skid_v) begin
        out_v   <= 1'b1;
        out_amp <= skid_amp;
        out_bad <= skid_bad;
        skid_v  <= 1'b0;
      end else begin
        out_v   <= r_ctl.valid;
        out_amp <= r_amp;
        out_bad <= (r_ctl.op == OP_BAD);
      end
    end else if (en && r_ctl.valid) begin
      skid_v   <= 1'b1;
      skid_amp <= r_amp;
      skid_bad <= (r_ctl.op == OP_BAD);
    end
  end

  assign m_tvalid   = out_v;
  assign m_tdata    = out_amp;
  assign m_tuser[0] = out_bad;

  `DCRP_ASSERT(a_skid_needs_out, clk, rst, skid_v, out_v, "skid full with empty output")
  `DCRP_ASSERT_NEXT(a_skid_holds, clk, rst, skid_v && !m_tready, skid_v, "skid item lost")
  `DCRP_ASSERT(a_bad_value, clk, rst, out_v && out_bad, out_amp == ERR_AMP, "bad item value")

endmodule
`default_nettype wire

@@ tb/double_couple_radiation_pattern_core_tb.sv @@
// Self-checking testbench for the double-couple radiation pattern core.
`timescale 1ns / 100ps
`default_nettype none
module double_couple_radiation_pattern_core_tb;
  import dcrp_pkg::*;

  localparam int FRAC = 14;
  localparam int LATENCY = 42;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;    // ray_azimuth[15:0], takeoff_angle[30:16]
  logic [1:0]  s_tuser;    // op[1:0]
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;    // amplitude[15:0]
  logic [0:0]  m_tuser;    // bad_component[0]
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_wdata;

  double_couple_radiation_pattern_core #(.AMP_FRAC_BITS(FRAC)) DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  typedef struct {
    logic [15:0] amp;
    logic        bad;
  } amp_t;

  typedef struct {
    logic [15:0] az;
    logic [14:0] tk;
    op_t         op;
    logic        known;   // expected result typed in below
    logic [15:0] amp;
    logic        bad;
  } row_t;

  localparam logic [31:0] ATAN [30] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
  };

  logic [15:0]        strike_q;
  logic [13:0]        dip_q;
  logic signed [15:0] rake_q;

  amp_t   pending_amps[$];
  int     fail_count;
  logic   tail_phase;
  logic   hold_rx;
  int     rx_hold_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50000000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Products of Q1.30 values, rounded half up.
  function automatic longint qprod(input longint a, input longint b);
    return (a * b + (64'sd1 <<< 29)) >>> 30;
  endfunction

  function automatic logic [31:0] hundredths_to_bang(input longint h);
    longint m;
    m = h % 36000;
    if (m < 0) m += 36000;
    return 32'(((longint'(m) <<< 32) + 18000) / 36000);
  endfunction

  task automatic cordic_sincos(input longint h, output longint sn, output longint cs);
    logic [31:0] z;
    logic        flip;
    longint      r, x, y, nx;
    z = hundredths_to_bang(h);
    flip = 1'b0;
    x = 652032874;
    y = 0;
    if (z - 32'h40000000 < 32'h80000000) begin
      z = z + 32'h80000000;
      flip = 1'b1;
    end
    r = longint'($signed(z));
    for (int i = 0; i < 30; i++) begin
      if (r >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        r -= longint'(ATAN[i]);
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        r += longint'(ATAN[i]);
      end
      x = nx;
    end
    sn = flip ? -y : y;
    cs = flip ? -x : x;
  endtask

  function automatic logic [15:0] to_amp(input longint v);
    int k;
    k = 30 - FRAC;
    if (k > 0) v = (v + (64'sd1 <<< (k - 1))) >>> k;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return 16'(v);
  endfunction

  task automatic predict_amplitude(input logic [15:0] az, input logic [14:0] tk,
                                   input op_t op, output amp_t res);
    longint sr, cr, sd, cd, s2d, c2d, st, ct, s2t, c2t, sa, ca, s2a, c2a;
    longint st2, sa2, amp, da, half, one;
    half = 64'sd1 <<< 29;
    one = 64'sd1 <<< 30;
    res.bad = (op == OP_BAD);
    if (op == OP_BAD) begin
      res.amp = to_amp(-one);
      return;
    end
    da = longint'(az) - longint'(strike_q);
    cordic_sincos(longint'(rake_q), sr, cr);
    cordic_sincos(longint'(dip_q), sd, cd);
    cordic_sincos(2 * longint'(dip_q), s2d, c2d);
    cordic_sincos(longint'(tk), st, ct);
    cordic_sincos(2 * longint'(tk), s2t, c2t);
    cordic_sincos(da, sa, ca);
    cordic_sincos(2 * da, s2a, c2a);
    st2 = qprod(st, st);
    sa2 = qprod(sa, sa);
    case (op)
      OP_P: amp = qprod(qprod(qprod(cr, sd), st2), s2a)
                - qprod(qprod(qprod(cr, cd), s2t), ca)
                + qprod(qprod(sr, s2d), qprod(ct, ct) - qprod(st2, sa2))
                + qprod(qprod(qprod(sr, c2d), s2t), sa);
      OP_SV: amp = qprod(qprod(qprod(sr, c2d), c2t), sa)
                 - qprod(qprod(qprod(cr, cd), c2t), ca)
                 + qprod(qprod(qprod(half, cr), sd), qprod(s2t, s2a))
                 - qprod(qprod(qprod(half, sr), s2d), qprod(s2t, one + sa2));
      default: amp = qprod(qprod(qprod(cr, cd), ct), sa)
                   + qprod(qprod(qprod(cr, sd), st), c2a)
                   + qprod(qprod(qprod(sr, c2d), ct), ca)
                   - qprod(qprod(qprod(half, sr), s2d), qprod(st, s2a));
    endcase
    res.amp = to_amp(amp);
  endtask

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    fail_count++;
    $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
  endtask

  // Result side: random stalls, optional long hold, checking.
  initial begin
    int gap;
    amp_t want;
    m_tready = 1'b0;
    gap = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        if (pending_amps.size() == 0) begin
          report_mismatch("unexpected item", m_tdata, 16'h0);
        end else begin
          want = pending_amps.pop_front();
          if (m_tdata !== want.amp) report_mismatch("amplitude", m_tdata, want.amp);
          if (m_tuser[0] !== want.bad) begin
            report_mismatch("bad_component", 16'(m_tuser), 16'(want.bad));
          end
        end
      end
      if (hold_rx) begin
        m_tready <= 1'b0;
        rx_hold_cycles++;
      end else if (gap > 0) begin
        m_tready <= 1'b0;
        gap--;
      end else if (!tail_phase && $urandom_range(0, 9) == 0) begin
        m_tready <= 1'b0;
        gap = $urandom_range(1, 19) - 1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Write enable is dropped for a cycle between writes.
  task automatic write_reg(input reg_idx_t idx, input logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_STRIKE: strike_q = val;
      REG_DIP: dip_q = val[13:0];
      REG_RAKE: rake_q = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic wait_drained();
    int guard;
    guard = 0;
    while (pending_amps.size() != 0) @(posedge clk);
    while (guard < LATENCY + 4) begin
      @(posedge clk);
      guard++;
    end
  endtask

  // Offers one item; when may_idle is set, a random sender gap may come before the item.
  task automatic send_ray(input logic [15:0] az, input logic [14:0] tk, input op_t op,
                          input logic may_idle);
    amp_t res;
    int n;
    if (may_idle && !tail_phase && $urandom_range(0, 9) == 0) begin
      n = $urandom_range(1, 19);
      s_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {1'b0, tk, az};
    s_tuser <= op;
    predict_amplitude(az, tk, op, res);
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_amps.push_back(res);
  endtask

  task automatic send_row(input row_t r);
    amp_t res;
    predict_amplitude(r.az, r.tk, r.op, res);
    if (r.known && (res.amp !== r.amp || res.bad !== r.bad)) begin
      report_mismatch("typed row", res.amp, r.amp);
    end
    send_ray(r.az, r.tk, r.op, 1'b1);
  endtask

  task automatic random_settings();
    write_reg(REG_STRIKE, 16'($urandom_range(0, 35999)));
    write_reg(REG_DIP, 16'($urandom_range(0, 9000)));
    write_reg(REG_RAKE, 16'($urandom_range(0, 36000) - 18000));
  endtask

  task automatic random_ray();
    logic [15:0] az;
    logic [14:0] tk;
    int pick;
    pick = $urandom_range(0, 19);
    az = (pick == 0) ? 16'($urandom) : 16'($urandom_range(0, 35999));
    tk = (pick == 1) ? 15'($urandom) : 15'($urandom_range(0, 18000));
    send_ray(az, tk, op_t'($urandom_range(0, 3)), 1'b1);
  endtask

  row_t directed_rows[] = '{
    // With every register at zero, P at azimuth 0 and take-off 0 is zero.
    '{16'd0,     15'd0,     OP_P,   1'b1, 16'h0000, 1'b0},
    '{16'd0,     15'd0,     OP_BAD, 1'b1, 16'hC000, 1'b1},
    '{16'd35999, 15'd18000, OP_BAD, 1'b1, 16'hC000, 1'b1},
    '{16'd0,     15'd9000,  OP_SV,  1'b0, 16'h0,    1'b0},
    '{16'd9000,  15'd9000,  OP_SH,  1'b0, 16'h0,    1'b0},
    '{16'd35999, 15'd18000, OP_P,   1'b0, 16'h0,    1'b0},
    '{16'd35999, 15'd18000, OP_SV,  1'b0, 16'h0,    1'b0},
    '{16'd35999, 15'd18000, OP_SH,  1'b0, 16'h0,    1'b0},
    '{16'hFFFF,  15'h7FFF,  OP_P,   1'b0, 16'h0,    1'b0},
    '{16'hFFFF,  15'h7FFF,  OP_SV,  1'b0, 16'h0,    1'b0},
    '{16'hFFFF,  15'h7FFF,  OP_SH,  1'b0, 16'h0,    1'b0},
    '{16'h5555,  15'h2AAA,  OP_P,   1'b0, 16'h0,    1'b0},
    '{16'hAAAA,  15'h5555,  OP_SH,  1'b0, 16'h0,    1'b0},
    '{16'd4500,  15'd4500,  OP_SV,  1'b0, 16'h0,    1'b0}
  };

  initial begin
    int tries;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    cfg_we = 1'b0;
    cfg_index = REG_STRIKE;
    cfg_wdata = '0;
    strike_q = '0;
    dip_q = '0;
    rake_q = '0;
    fail_count = 0;
    tail_phase = 1'b0;
    hold_rx = 1'b0;
    rx_hold_cycles = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) send_row(directed_rows[i]);
    s_tvalid <= 1'b0;
    wait_drained();

    // Extreme fault geometries, out-of-range register values and an unused index.
    write_reg(REG_STRIKE, 16'd35999);
    write_reg(REG_DIP, 16'd9000);
    write_reg(REG_RAKE, 16'h8000);
    write_reg(REG_NONE, 16'hFFFF);
    for (int i = 0; i < 8; i++) send_ray(16'(i * 4500), 15'(i * 2250), op_t'(i % 4), 1'b1);
    s_tvalid <= 1'b0;
    wait_drained();
    write_reg(REG_STRIKE, 16'hFFFF);
    write_reg(REG_DIP, 16'h3FFF);
    write_reg(REG_RAKE, 16'h7FFF);
    for (int i = 0; i < 8; i++) send_ray(16'($urandom), 15'($urandom), op_t'(i % 3), 1'b1);
    s_tvalid <= 1'b0;
    wait_drained();
    write_reg(REG_RAKE, 16'(-18000));
    write_reg(REG_DIP, 16'd0);
    write_reg(REG_STRIKE, 16'd0);

    // The receiver stops while the sender keeps offering items.
    fork
      begin
        hold_rx = 1'b1;
        while (rx_hold_cycles < 200) @(posedge clk);
        hold_rx = 1'b0;
      end
      for (int i = 0; i < 80; i++) random_ray();
    join
    s_tvalid <= 1'b0;
    wait_drained();

    for (int phase = 0; phase < 8; phase++) begin
      random_settings();
      if (phase == 7) tail_phase = 1'b1;
      for (int i = 0; i < 105; i++) random_ray();
      s_tvalid <= 1'b0;
      wait_drained();
    end

    tries = 0;
    while (pending_amps.size() != 0 && tries < 10000) begin
      @(posedge clk);
      tries++;
    end
    if (fail_count == 0 && pending_amps.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/dcrp_pkg.sv
hw/rtl/dcrp_angle.sv
hw/rtl/dcrp_cordic.sv
hw/rtl/dcrp_combine.sv
hw/rtl/double_couple_radiation_pattern_core.sv
tb/double_couple_radiation_pattern_core_tb.sv
